FILE: rtl/lz77_sliding_window_encoder_defines.svh
// Assertion macros for the LZ77 sliding-window encoder.
// Used by the top level only; no other dependencies.
`ifndef LZ77_SLIDING_WINDOW_ENCODER_DEFINES_SVH
`define LZ77_SLIDING_WINDOW_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define LZSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lzsw check failed");
`define LZSW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("lzsw check failed");
`else
`define LZSW_ASSERT(lbl, clk, rst, prop)
`define LZSW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/lzsw_pkg.sv
// Types, sizes and codes shared by the LZ77 sliding-window encoder.
// No dependencies.
package lzsw_pkg;
   localparam int WINDOW_DEPTH    = 1024;
   localparam int LOOKAHEAD_DEPTH = 16;
   localparam int AW   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int LI_W = $clog2(LOOKAHEAD_DEPTH);
   localparam int LC_W = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int WL_W = 11;
   localparam int ML_W = 5;
   localparam int OFF_W = 10;
   localparam int LEN_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [WL_W-1:0] WINDOW_LIMIT_RESET = 11'd1024;
   localparam logic [ML_W-1:0] MATCH_LIMIT_RESET = 5'd16;
   localparam logic [7:0] NUL_BYTE = 8'd0;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_LIMIT  = 2'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] match_length;
      logic [7:0]       next_byte;
      logic             final_token;
   } rsp_type;

   typedef struct packed {
      logic la_shift;
      logic tap_shift;
   } cell_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic clear;
   } hist_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SEARCH, ST_EMIT, ST_CONSUME, ST_ENDTOK, ST_CLEAR
   } state_type;
endpackage

FILE: rtl/lzsw_cell.sv
// One comparator cell: a lookahead byte and a history tap.
// Depends on lzsw_pkg.
module lzsw_cell (
   input  logic                  clock,
   input  lzsw_pkg::cell_ctl_type ctl,
   input  logic                  load_en,
   input  logic [7:0]            load_byte,
   input  logic [7:0]            la_right,
   input  logic [7:0]            hist_in,
   input  logic                  en,
   input  logic                  run_in,
   output logic [7:0]            la_byte,
   output logic [7:0]            tap_out,
   output logic                  run_out
);
   logic [7:0] la_ff;
   logic [7:0] tap_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         la_ff <= load_byte;
      end else if (ctl.la_shift) begin
         la_ff <= la_right;
      end
      if (ctl.tap_shift) begin
         tap_ff <= hist_in;
      end
   end

   assign la_byte = la_ff;
   assign tap_out = tap_ff;
   // extend the match run only while every earlier cell matched
   assign run_out = run_in & en & (la_ff == hist_in);
endmodule

FILE: rtl/lzsw_history.sv
// History window: byte memory, circular head and fill count.
// Depends on lzsw_pkg.
module lzsw_history (
   input  logic                        clock,
   input  logic                        reset,
   input  lzsw_pkg::hist_ctl_type      ctl,
   input  logic [7:0]                  wr_byte,
   input  logic [lzsw_pkg::CNT_W-1:0]  rd_dist,
   input  logic [lzsw_pkg::CNT_W-1:0]  wl_eff,
   output logic [7:0]                  rd_byte,
   output logic [lzsw_pkg::CNT_W-1:0]  hist_count
);
   logic [7:0] mem [lzsw_pkg::WINDOW_DEPTH];
   logic [lzsw_pkg::AW-1:0] head_ff, head_in, rd_addr, dist_a;
   logic [lzsw_pkg::CNT_W-1:0] count_ff, count_in;
   logic [7:0] rd_q_ff;

   always_comb begin
      head_in = (32'(head_ff) == lzsw_pkg::WINDOW_DEPTH - 1) ? '0 : head_ff + 1'b1;
      dist_a  = lzsw_pkg::AW'(rd_dist);
      if (head_ff >= dist_a) begin
         rd_addr = head_ff - dist_a;
      end else begin
         rd_addr = lzsw_pkg::AW'(32'(head_ff) + lzsw_pkg::WINDOW_DEPTH - 32'(dist_a));
      end
      count_in = (count_ff < wl_eff) ? count_ff + 1'b1 : wl_eff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctl.wr_en) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[head_in] <= wr_byte;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_byte    = rd_q_ff;
   assign hist_count = (count_ff < wl_eff) ? count_ff : wl_eff;
endmodule

FILE: rtl/lz77_sliding_window_encoder.sv
// Top level of the LZ77 sliding-window encoder: control, cell row, output register.
// Depends on lzsw_pkg, lzsw_cell, lzsw_history and the defines header.
//
//   channel | ports                          | role
//   req     | req_valid req_stall req_payload | raw byte plus stream end flag in
//   rsp     | rsp_valid rsp_stall rsp_payload | tokens out, none or several per item
//   csr     | csr_valid csr_ready csr_index csr_data | window and match limits
//
// Each token takes a check step, a sweep of the history memory, one offset per cycle
// through its single read port (hc = bytes held, cut short once a capped match is
// found), the emit step, then the consume step, in which the history write port takes
// a byte a cycle while the lookahead cells shift left.
// An item producing no token returns to idle from the check step. End of stream adds a
// clear step, plus an end token step when one is sent.
// Reset is synchronous and clears control state only; memory content is
// undefined until written. Input is stalled and configuration refused during reset.
// A stalled token holds the search at the emit step;
// new items are taken only when the previous item's work is done.
`include "lz77_sliding_window_encoder_defines.svh"
module lz77_sliding_window_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lzsw_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lzsw_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lzsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lzsw_pkg::CSR_DATA_W-1:0]     csr_data
);
   localparam int LD = lzsw_pkg::LOOKAHEAD_DEPTH;
   localparam int LC_W = lzsw_pkg::LC_W;
   localparam int LI_W = lzsw_pkg::LI_W;
   localparam int CNT_W = lzsw_pkg::CNT_W;

   lzsw_pkg::state_type state_ff, state_in;

   // configuration
   logic [lzsw_pkg::WL_W-1:0] wlim_ff;
   logic [lzsw_pkg::ML_W-1:0] mlim_ff;
   logic [CNT_W-1:0] wl_eff;
   logic [LC_W-1:0]  ml_eff;
   logic [LI_W-1:0]  cap;

   // lookahead bookkeeping
   logic [LC_W-1:0] la_count_ff, la_count_in;
   logic            end_ff;
   logic            lit_ff;
   logic [LC_W-1:0] cons_left_ff;

   // search
   logic [CNT_W-1:0] rd_d_ff, cmp_d_ff, hc;
   logic             cmp_v_ff;
   logic [LI_W-1:0]  best_len_ff, tl_raw, tl;
   logic [CNT_W-1:0] best_off_ff;
   logic             issue, better, early, done_now;

   // token
   logic [LC_W-1:0] n_take, remaining;
   logic            slot_free;
   logic            rsp_valid_ff;
   lzsw_pkg::rsp_type rsp_ff;

   // control strobes
   logic accept, search_init, emit_load, endtok_load, consume, do_clear;

   // cell row
   lzsw_pkg::cell_ctl_type cctl;
   lzsw_pkg::hist_ctl_type hctl;
   logic [7:0] la_byte [LD];
   logic [7:0] tap [LD];
   logic [LD-1:0] run, en, load_en;
   logic [7:0] mem_q;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !reset;

   // effective limits: saturate to the store sizes, a zero match limit acts as one
   always_comb begin
      wl_eff = (32'(wlim_ff) > lzsw_pkg::WINDOW_DEPTH) ?
               CNT_W'(lzsw_pkg::WINDOW_DEPTH) : CNT_W'(wlim_ff);
      if (mlim_ff == '0) begin
         ml_eff = LC_W'(1);
      end else if (32'(mlim_ff) > LD) begin
         ml_eff = LC_W'(LD);
      end else begin
         ml_eff = LC_W'(mlim_ff);
      end
      cap = LI_W'(ml_eff - 1'b1);
   end

   // match evaluation on the cell row
   always_comb begin
      tl_raw = '0;
      for (int p = 0; p < LD; p++) begin
         if (run[p]) begin
            tl_raw = LI_W'(p);
         end
      end
      tl       = (tl_raw > cap) ? cap : tl_raw;
      better   = cmp_v_ff && (tl > best_len_ff);
      early    = better && (tl == cap);
      done_now = (hc == '0) || (cmp_v_ff && ((cmp_d_ff == hc - 1'b1) || early));
      issue    = (state_ff == lzsw_pkg::ST_SEARCH) && (rd_d_ff < hc) && !done_now;
      n_take   = (LC_W'(best_len_ff) + 1'b1 > la_count_ff) ?
                 la_count_ff : LC_W'(best_len_ff) + 1'b1;
      remaining = la_count_ff - n_take;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzsw_pkg::ST_IDLE: begin
            if (accept) state_in = lzsw_pkg::ST_CHECK;
         end
         lzsw_pkg::ST_CHECK: begin
            if (end_ff) begin
               if (la_count_ff != '0) state_in = lzsw_pkg::ST_SEARCH;
               else if (lit_ff)       state_in = lzsw_pkg::ST_ENDTOK;
               else                   state_in = lzsw_pkg::ST_CLEAR;
            end else if (la_count_ff >= ml_eff) begin
               state_in = lzsw_pkg::ST_SEARCH;
            end else begin
               state_in = lzsw_pkg::ST_IDLE;
            end
         end
         lzsw_pkg::ST_SEARCH: begin
            if (done_now) state_in = lzsw_pkg::ST_EMIT;
         end
         lzsw_pkg::ST_EMIT: begin
            if (slot_free) state_in = lzsw_pkg::ST_CONSUME;
         end
         lzsw_pkg::ST_CONSUME: begin
            if (cons_left_ff == LC_W'(1)) state_in = lzsw_pkg::ST_CHECK;
         end
         lzsw_pkg::ST_ENDTOK: begin
            if (slot_free) state_in = lzsw_pkg::ST_CLEAR;
         end
         lzsw_pkg::ST_CLEAR: begin
            state_in = lzsw_pkg::ST_IDLE;
         end
         default: state_in = lzsw_pkg::ST_IDLE;
      endcase
   end

   // control strobes per state
   always_comb begin
      req_stall   = reset || (state_ff != lzsw_pkg::ST_IDLE);
      search_init = (state_ff == lzsw_pkg::ST_CHECK) && (state_in == lzsw_pkg::ST_SEARCH);
      emit_load   = (state_ff == lzsw_pkg::ST_EMIT) && slot_free;
      endtok_load = (state_ff == lzsw_pkg::ST_ENDTOK) && slot_free;
      consume     = (state_ff == lzsw_pkg::ST_CONSUME);
      do_clear    = (state_ff == lzsw_pkg::ST_CLEAR);
      cctl.la_shift  = consume;
      cctl.tap_shift = cmp_v_ff;
      hctl.wr_en     = consume;
      hctl.clear     = do_clear;
      la_count_in = la_count_ff;
      if (accept && (32'(la_count_ff) < LD)) begin
         la_count_in = la_count_ff + 1'b1;
      end else if (consume) begin
         la_count_in = la_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzsw_pkg::ST_IDLE;
         wlim_ff      <= lzsw_pkg::WINDOW_LIMIT_RESET;
         mlim_ff      <= lzsw_pkg::MATCH_LIMIT_RESET;
         la_count_ff  <= '0;
         end_ff       <= 1'b0;
         lit_ff       <= 1'b0;
         cons_left_ff <= '0;
         cmp_v_ff     <= 1'b0;
         rd_d_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         la_count_ff <= la_count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lzsw_pkg::REG_WINDOW_LIMIT: wlim_ff <= csr_data[lzsw_pkg::WL_W-1:0];
               lzsw_pkg::REG_MATCH_LIMIT:  mlim_ff <= csr_data[lzsw_pkg::ML_W-1:0];
               default: ;
            endcase
         end
         if (accept) end_ff <= req_payload.stream_end;
         // hold the sweep counters; restart them for each token
         if (search_init) begin
            rd_d_ff <= '0;
         end else if (issue) begin
            rd_d_ff <= rd_d_ff + 1'b1;
         end
         cmp_v_ff <= issue;
         if (emit_load) begin
            lit_ff       <= (best_len_ff == '0);
            cons_left_ff <= n_take;
         end else if (consume) begin
            cons_left_ff <= cons_left_ff - 1'b1;
         end
         if (emit_load || endtok_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_d_ff <= rd_d_ff;
      if (search_init) begin
         best_len_ff <= '0;
         best_off_ff <= '0;
      end else if (better) begin
         best_len_ff <= tl;
         best_off_ff <= cmp_d_ff;
      end
      if (emit_load) begin
         rsp_ff.offset       <= (best_len_ff == '0) ? '0 : lzsw_pkg::OFF_W'(best_off_ff);
         rsp_ff.match_length <= lzsw_pkg::LEN_W'(best_len_ff);
         rsp_ff.next_byte    <= la_byte[best_len_ff];
         // last token of the item: lookahead drained below the limit, or at
         // end of stream drained with a match (a literal gets an end token)
         rsp_ff.final_token  <= end_ff ? ((remaining == '0) && (best_len_ff != '0))
                                       : (remaining < ml_eff);
      end else if (endtok_load) begin
         rsp_ff.offset       <= '0;
         rsp_ff.match_length <= '0;
         rsp_ff.next_byte    <= lzsw_pkg::NUL_BYTE;
         rsp_ff.final_token  <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   lzsw_history u_history (
      .clock      (clock),
      .reset      (reset),
      .ctl        (hctl),
      .wr_byte    (la_byte[0]),
      .rd_dist    (rd_d_ff),
      .wl_eff     (wl_eff),
      .rd_byte    (mem_q),
      .hist_count (hc)
   );

   // row of cells: lookahead bytes shift left, history taps shift right
   for (genvar p = 0; p < LD; p++) begin : g_cell
      logic [7:0] la_right, hist_in;
      logic       run_in;
      assign la_right   = (p == LD - 1) ? lzsw_pkg::NUL_BYTE : la_byte[(p + 1) % LD];
      assign hist_in    = (p == 0) ? mem_q : tap[(p + LD - 1) % LD];
      assign run_in     = (p == 0) ? 1'b1 : run[(p + LD - 1) % LD];
      assign en[p]      = (32'(la_count_ff) > p) && (32'(cmp_d_ff) >= p);
      assign load_en[p] = accept && (32'(la_count_ff) == p);
      lzsw_cell u_cell (
         .clock     (clock),
         .ctl       (cctl),
         .load_en   (load_en[p]),
         .load_byte (req_payload.data_byte),
         .la_right  (la_right),
         .hist_in   (hist_in),
         .en        (en[p]),
         .run_in    (run_in),
         .la_byte   (la_byte[p]),
         .tap_out   (tap[p]),
         .run_out   (run[p])
      );
   end

   `LZSW_ASSERT(a_la_bound, clock, reset, la_count_ff <= LC_W'(LD))
   `LZSW_ASSERT(a_clear_empties, clock, reset, (state_ff == lzsw_pkg::ST_CLEAR) |=> (hc == '0))
   `LZSW_ASSERT(a_consume_left, clock, reset, (state_ff == lzsw_pkg::ST_CONSUME) |-> (cons_left_ff != '0))
   `LZSW_ASSERT(a_search_has_bytes, clock, reset, (state_ff == lzsw_pkg::ST_SEARCH) |-> (la_count_ff != '0))
endmodule
